>>> src/isim_pkg.sv
// Shared types and constants for the interval set insert/merge core.
`timescale 1ns / 1ps
package isim_pkg;

  // Port width of every coordinate field
  localparam int FIELD_W = 32;

  // Default sizing
  localparam int CAPACITY_DEF = 16;
  localparam int COORD_W_DEF  = 32;

  // Item actions
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Status codes carried by every result beat of one item
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_ORDER = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_COMMIT,
    ST_EMIT
  } isim_state_t;

  // Compare results of one stored entry against the accumulated interval
  typedef struct packed {
    logic below;       // entry ends below the accumulated start
    logic hits;        // entry starts at or below the accumulated end
    logic lower_start; // entry start extends the accumulated start
    logic higher_end;  // entry end extends the accumulated end
  } step_flags_t;

endpackage

>>> src/isim_step_unit.sv
// Shared compare unit: classifies one stored entry against the accumulated interval.
`timescale 1ns / 1ps
module isim_step_unit #(
  parameter int COORD_WIDTH = isim_pkg::COORD_W_DEF
) (
  input  logic [COORD_WIDTH-1:0] ent_start,
  input  logic [COORD_WIDTH-1:0] ent_end,
  input  logic [COORD_WIDTH-1:0] acc_start,
  input  logic [COORD_WIDTH-1:0] acc_end,
  output isim_pkg::step_flags_t  flags,
  output logic [COORD_WIDTH-1:0] mrg_start,
  output logic [COORD_WIDTH-1:0] mrg_end
);

  // Signed compares of the entry against the accumulated bounds
  always_comb begin
    flags.below       = $signed(ent_end) < $signed(acc_start);
    flags.hits        = $signed(ent_start) <= $signed(acc_end);
    flags.lower_start = $signed(ent_start) < $signed(acc_start);
    flags.higher_end  = $signed(ent_end) > $signed(acc_end);
  end

  // Widen the accumulated interval to cover the entry
  assign mrg_start = flags.lower_start ? ent_start : acc_start;
  assign mrg_end   = flags.higher_end ? ent_end : acc_end;

endmodule

>>> src/isim_table.sv
// Two-bank interval table: one bank is live, the other receives the rebuilt table.
`timescale 1ns / 1ps
module isim_table #(
  parameter int CAPACITY    = isim_pkg::CAPACITY_DEF,
  parameter int COORD_WIDTH = isim_pkg::COORD_W_DEF,
  parameter int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic                   wr_bank,
  input  logic [IDX_W-1:0]       wr_idx,
  input  logic [COORD_WIDTH-1:0] wr_start,
  input  logic [COORD_WIDTH-1:0] wr_end,
  input  logic                   rd_bank,
  input  logic [IDX_W-1:0]       rd_idx,
  output logic [COORD_WIDTH-1:0] rd_start,
  output logic [COORD_WIDTH-1:0] rd_end
);

  logic [COORD_WIDTH-1:0] start_mem [0:1][0:CAPACITY-1];
  logic [COORD_WIDTH-1:0] end_mem   [0:1][0:CAPACITY-1];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_bank][wr_idx] <= wr_start;
      end_mem[wr_bank][wr_idx]   <= wr_end;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_start <= start_mem[rd_bank][rd_idx];
    rd_end   <= end_mem[rd_bank][rd_idx];
  end

endmodule

>>> src/interval_set_insert_merge_core.sv
// Top level: sequencer that walks, merges, commits and emits the sorted interval table.
// Insert: an accept step, a walk over the N stored entries through one compare unit and one
// table read port, a commit step, then one beat per stored entry.
// Clear and start-above-end items skip the walk; output stalls hold the emit.
// Reset (synchronous, rst_n low) empties the table and drops any pending result beat.
`timescale 1ns / 1ps
module interval_set_insert_merge_core #(
  parameter int CAPACITY    = isim_pkg::CAPACITY_DEF,
  parameter int COORD_WIDTH = isim_pkg::COORD_W_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic signed [isim_pkg::FIELD_W-1:0] in_new_start,
  input  logic signed [isim_pkg::FIELD_W-1:0] in_new_end,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [isim_pkg::FIELD_W-1:0] out_entry_start,
  output logic signed [isim_pkg::FIELD_W-1:0] out_entry_end,
  output logic                                out_entry_valid,
  output logic                                out_last,
  output logic [1:0]                          out_status
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Control state
  isim_pkg::isim_state_t state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] wpos_r, wpos_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             bank_r, bank_nxt;
  logic             placed_r, placed_nxt;
  logic             merged_r, merged_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload state
  logic [COORD_WIDTH-1:0]         acc_start_r, acc_start_nxt;
  logic [COORD_WIDTH-1:0]         acc_end_r, acc_end_nxt;
  logic [isim_pkg::FIELD_W-1:0]   out_start_r, out_start_nxt;
  logic [isim_pkg::FIELD_W-1:0]   out_end_r, out_end_nxt;
  logic                           out_entry_valid_r, out_entry_valid_nxt;
  logic                           out_last_r, out_last_nxt;
  logic [1:0]                     out_status_r, out_status_nxt;

  // Datapath wires
  logic                   in_accept;
  logic                   emit_load;
  logic                   emit_final;
  logic                   walk_done;
  logic                   drop_full;
  logic [COORD_WIDTH-1:0] new_start;
  logic [COORD_WIDTH-1:0] new_end;
  logic [COORD_WIDTH-1:0] rd_start;
  logic [COORD_WIDTH-1:0] rd_end;
  logic [COORD_WIDTH-1:0] mrg_start;
  logic [COORD_WIDTH-1:0] mrg_end;
  isim_pkg::step_flags_t  flags;
  logic                   wr_en;
  logic [COORD_WIDTH-1:0] wr_start;
  logic [COORD_WIDTH-1:0] wr_end;

  // Handshake and input conversion
  assign in_stall   = (state_r != isim_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign new_start  = COORD_WIDTH'(in_new_start);
  assign new_end    = COORD_WIDTH'(in_new_end);
  assign emit_load  = (state_r == isim_pkg::ST_EMIT) && (!out_valid_r || !out_stall);
  assign emit_final = (count_r == '0) || ((idx_r + CNT_W'(1)) == count_r);
  assign walk_done  = (idx_r == count_r);
  assign drop_full  = !merged_r && (count_r == CAP_CNT);

  // Shared compare unit
  isim_step_unit #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_step (
    .ent_start(rd_start),
    .ent_end  (rd_end),
    .acc_start(acc_start_r),
    .acc_end  (acc_end_r),
    .flags    (flags),
    .mrg_start(mrg_start),
    .mrg_end  (mrg_end)
  );

  // Table storage
  isim_table #(
    .CAPACITY   (CAPACITY),
    .COORD_WIDTH(COORD_WIDTH),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_bank (~bank_r),
    .wr_idx  (wpos_r[IDX_W-1:0]),
    .wr_start(wr_start),
    .wr_end  (wr_end),
    .rd_bank (bank_nxt),
    .rd_idx  (idx_nxt[IDX_W-1:0]),
    .rd_start(rd_start),
    .rd_end  (rd_end)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      isim_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_action == isim_pkg::ACT_CLEAR) begin
            state_nxt = isim_pkg::ST_EMIT;
          end else if ($signed(new_start) > $signed(new_end)) begin
            state_nxt = isim_pkg::ST_EMIT;
          end else begin
            state_nxt = isim_pkg::ST_WALK;
          end
        end
      end
      isim_pkg::ST_WALK: begin
        if (walk_done) begin
          state_nxt = isim_pkg::ST_COMMIT;
        end
      end
      isim_pkg::ST_COMMIT: begin
        state_nxt = isim_pkg::ST_EMIT;
      end
      isim_pkg::ST_EMIT: begin
        if (emit_load && emit_final) begin
          state_nxt = isim_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = isim_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and table control per state
  always_comb begin
    idx_nxt       = idx_r;
    wpos_nxt      = wpos_r;
    count_nxt     = count_r;
    bank_nxt      = bank_r;
    placed_nxt    = placed_r;
    merged_nxt    = merged_r;
    status_nxt    = status_r;
    acc_start_nxt = acc_start_r;
    acc_end_nxt   = acc_end_r;
    wr_en         = 1'b0;
    wr_start      = acc_start_r;
    wr_end        = acc_end_r;
    unique case (state_r)
      isim_pkg::ST_IDLE: begin
        if (in_accept) begin
          idx_nxt       = '0;
          wpos_nxt      = '0;
          placed_nxt    = 1'b0;
          merged_nxt    = 1'b0;
          acc_start_nxt = new_start;
          acc_end_nxt   = new_end;
          status_nxt    = isim_pkg::STAT_OK;
          if (in_action == isim_pkg::ACT_CLEAR) begin
            count_nxt = '0;
          end else if ($signed(new_start) > $signed(new_end)) begin
            status_nxt = isim_pkg::STAT_ORDER;
          end
        end
      end
      isim_pkg::ST_WALK: begin
        if (walk_done) begin
          // Place the new interval at the tail if nothing came after it
          if (!placed_r) begin
            wr_en    = (wpos_r < CAP_CNT);
            wpos_nxt = wpos_r + CNT_W'(1);
          end
        end else if (flags.below) begin
          // Copy an entry that lies below the new interval
          wr_en    = (wpos_r < CAP_CNT);
          wr_start = rd_start;
          wr_end   = rd_end;
          wpos_nxt = wpos_r + CNT_W'(1);
          idx_nxt  = idx_r + CNT_W'(1);
        end else if (flags.hits) begin
          // Absorb an overlapping or touching entry
          acc_start_nxt = mrg_start;
          acc_end_nxt   = mrg_end;
          merged_nxt    = 1'b1;
          idx_nxt       = idx_r + CNT_W'(1);
        end else if (!placed_r) begin
          // Place the new interval, hold this entry for the next cycle
          wr_en      = (wpos_r < CAP_CNT);
          wpos_nxt   = wpos_r + CNT_W'(1);
          placed_nxt = 1'b1;
        end else begin
          // Copy an entry that lies above the new interval
          wr_en    = (wpos_r < CAP_CNT);
          wr_start = rd_start;
          wr_end   = rd_end;
          wpos_nxt = wpos_r + CNT_W'(1);
          idx_nxt  = idx_r + CNT_W'(1);
        end
      end
      isim_pkg::ST_COMMIT: begin
        // Swap banks unless the insert found no room
        idx_nxt = '0;
        if (drop_full) begin
          status_nxt = isim_pkg::STAT_FULL;
        end else begin
          bank_nxt  = ~bank_r;
          count_nxt = wpos_r;
        end
      end
      isim_pkg::ST_EMIT: begin
        if (emit_load && !emit_final) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  // Output register load
  always_comb begin
    out_valid_nxt       = out_valid_r && out_stall;
    out_start_nxt       = out_start_r;
    out_end_nxt         = out_end_r;
    out_entry_valid_nxt = out_entry_valid_r;
    out_last_nxt        = out_last_r;
    out_status_nxt      = out_status_r;
    if (emit_load) begin
      out_valid_nxt  = 1'b1;
      out_last_nxt   = emit_final;
      out_status_nxt = status_r;
      if (count_r == '0) begin
        out_start_nxt       = '0;
        out_end_nxt         = '0;
        out_entry_valid_nxt = 1'b0;
      end else begin
        out_start_nxt       = isim_pkg::FIELD_W'(rd_start);
        out_end_nxt         = isim_pkg::FIELD_W'(rd_end);
        out_entry_valid_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isim_pkg::ST_IDLE;
      idx_r       <= '0;
      wpos_r      <= '0;
      count_r     <= '0;
      bank_r      <= 1'b0;
      placed_r    <= 1'b0;
      merged_r    <= 1'b0;
      status_r    <= isim_pkg::STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      wpos_r      <= wpos_nxt;
      count_r     <= count_nxt;
      bank_r      <= bank_nxt;
      placed_r    <= placed_nxt;
      merged_r    <= merged_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_start_r       <= acc_start_nxt;
    acc_end_r         <= acc_end_nxt;
    out_start_r       <= out_start_nxt;
    out_end_r         <= out_end_nxt;
    out_entry_valid_r <= out_entry_valid_nxt;
    out_last_r        <= out_last_nxt;
    out_status_r      <= out_status_nxt;
  end

  // Result ports
  assign out_valid       = out_valid_r;
  assign out_entry_start = out_start_r;
  assign out_entry_end   = out_end_r;
  assign out_entry_valid = out_entry_valid_r;
  assign out_last        = out_last_r;
  assign out_status      = out_status_r;

`ifndef SYNTHESIS
  // Table never holds more than its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  // Walk index never runs past the stored entries
  a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isim_pkg::ST_WALK) |-> (idx_r <= count_r))
    else $error("walk index past entry count");

  // A beat without an entry is the only beat of its item
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_entry_valid_r) |-> out_last_r)
    else $error("empty-table beat without last");

  // A committed insert leaves at least one entry
  a_commit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isim_pkg::ST_COMMIT && !drop_full) |=> (count_r != '0))
    else $error("committed insert left an empty table");
`endif

endmodule
